// ----- rtl/clem_pkg.sv -----
// ----------------------------------------------------------------------------
// clem_pkg
// Shared types and constants of the complete-linkage edge merger.
// ----------------------------------------------------------------------------
`default_nettype none

package clem_pkg;

	// Default number of leaf points.
	localparam int MAX_POINTS_DEF = 64;

	// Width of one pair count and its saturation value.
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Width of a Q16.16 distance.
	localparam int DIST_W = 32;

	// Configuration port geometry.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register index as seen on paddr bit 2.
	localparam logic REG_THRESHOLD  = 1'b0;
	localparam logic REG_NUM_POINTS = 1'b1;

	// Result flag positions in m_tuser.
	localparam int FLAG_MERGED   = 0;
	localparam int FLAG_FINISHED = 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OWN,
		ST_CNT,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN,
		ST_MOUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic eval_own;
		logic upd_cnt;
		logic sweep_rd;
		logic commit;
		logic emit_fin;
		logic emit_merge;
		logic clear_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic restart;
		logic ignore;
		logic stop_hit;
		logic pair_full;
		logic sweep_last;
		logic clear_last;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/complete_linkage_edge_merger_core.sv -----
// An in-range edge that merges nothing steps through accept, owner lookup and count update.
// A stopping edge steps through accept, owner lookup and result load; the load waits while the output is busy.
// A merging edge steps through accept, owner lookup, count update, a sweep over all cluster ids, commit and
// result load. A new edge is accepted only after the previous one has been fully handled.
// Reset and every num_points write run a clearing pass over all (2*MAX_POINTS)^2 words
// of the pair count memory; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// complete_linkage_edge_merger_core
// Complete-linkage clustering over a stream of point-pair edges.
// ----------------------------------------------------------------------------
`default_nettype none

module complete_linkage_edge_merger_core #(
	parameter int MAX_POINTS = clem_pkg::MAX_POINTS_DEF,
	localparam int PW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(2 * MAX_POINTS),
	localparam int IN_BITS = 2 * PW + clem_pkg::DIST_W,
	localparam int IN_W = (IN_BITS + 7) / 8 * 8,
	localparam int OUT_BITS = 3 * CW + clem_pkg::DIST_W,
	localparam int OUT_W = (OUT_BITS + 7) / 8 * 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// point_a, point_b, distance
	input  wire [IN_W-1:0]               s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// larger_child, smaller_child, new_cluster, merge_distance
	output logic [OUT_W-1:0]             m_tdata,
	// merged, finished
	output logic [1:0]                   m_tuser,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [clem_pkg::APB_AW-1:0]   paddr,
	input  wire [clem_pkg::APB_DW-1:0]   pwdata,
	output logic [clem_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	clem_pkg::cmd_t    cmd;
	clem_pkg::status_t status;

	logic [CW-1:0]               out_larger;
	logic [CW-1:0]               out_smaller;
	logic [CW-1:0]               out_new;
	logic [clem_pkg::DIST_W-1:0] out_distance;
	logic                        out_merged;
	logic                        out_finished;

	assign pready = 1'b1;

	clem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	clem_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.point_a      (s_tdata[PW-1:0]),
		.point_b      (s_tdata[2*PW-1:PW]),
		.distance     (s_tdata[IN_BITS-1:2*PW]),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_merged   (out_merged),
		.out_finished (out_finished),
		.out_larger   (out_larger),
		.out_smaller  (out_smaller),
		.out_new      (out_new),
		.out_distance (out_distance)
	);

	// Pack the result word, first field lowest.
	assign m_tdata = OUT_W'({out_distance, out_new, out_smaller, out_larger});
	assign m_tuser[clem_pkg::FLAG_MERGED]   = out_merged;
	assign m_tuser[clem_pkg::FLAG_FINISHED] = out_finished;

endmodule

`default_nettype wire

// ----- rtl/clem_ctrl.sv -----
// ----------------------------------------------------------------------------
// clem_ctrl
// Sequencer of the edge merger: steps each word through owner lookup,
// count update, merge sweep and result hand-off, and runs the clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module clem_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire clem_pkg::status_t  status,
	output clem_pkg::cmd_t          cmd
);

	clem_pkg::state_t state_q;
	clem_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clem_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			clem_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_nxt = clem_pkg::ST_IDLE;
				end
			end
			clem_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (!status.ignore) begin
						state_nxt = clem_pkg::ST_OWN;
					end
				end
			end
			clem_pkg::ST_OWN: begin
				cmd.eval_own = 1'b1;
				state_nxt = status.stop_hit ? clem_pkg::ST_FIN : clem_pkg::ST_CNT;
			end
			clem_pkg::ST_CNT: begin
				cmd.upd_cnt = 1'b1;
				state_nxt = status.pair_full ? clem_pkg::ST_SWEEP : clem_pkg::ST_IDLE;
			end
			clem_pkg::ST_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (status.sweep_last) begin
					state_nxt = clem_pkg::ST_DRAIN;
				end
			end
			clem_pkg::ST_DRAIN: begin
				cmd.commit = 1'b1;
				state_nxt = clem_pkg::ST_MOUT;
			end
			clem_pkg::ST_FIN: begin
				if (!status.out_busy) begin
					cmd.emit_fin = 1'b1;
					state_nxt = clem_pkg::ST_IDLE;
				end
			end
			clem_pkg::ST_MOUT: begin
				if (!status.out_busy) begin
					cmd.emit_merge = 1'b1;
					state_nxt = clem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = clem_pkg::ST_CLEAR;
			end
		endcase
		// A new point count restarts everything with a clearing pass.
		if (status.restart) begin
			state_nxt = clem_pkg::ST_CLEAR;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clem_datapath.sv -----
// ----------------------------------------------------------------------------
// clem_datapath
// Storage and arithmetic of the edge merger: leaf owners, cluster sizes,
// the pair count memory, the merge sweep pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clem_datapath #(
	parameter int MAX_POINTS = clem_pkg::MAX_POINTS_DEF,
	localparam int NUM_CL = 2 * MAX_POINTS,
	localparam int PW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(NUM_CL),
	localparam int NW = $clog2(MAX_POINTS + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire clem_pkg::cmd_t          cmd,
	output clem_pkg::status_t            status,
	input  wire [PW-1:0]                 point_a,
	input  wire [PW-1:0]                 point_b,
	input  wire [clem_pkg::DIST_W-1:0]   distance,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [clem_pkg::APB_AW-1:0]   paddr,
	input  wire [clem_pkg::APB_DW-1:0]   pwdata,
	output logic [clem_pkg::APB_DW-1:0]  prdata,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         out_merged,
	output logic                         out_finished,
	output logic [CW-1:0]                out_larger,
	output logic [CW-1:0]                out_smaller,
	output logic [CW-1:0]                out_new,
	output logic [clem_pkg::DIST_W-1:0]  out_distance
);

	localparam int CNT_DEPTH = NUM_CL * NUM_CL;
	localparam int AW = $clog2(CNT_DEPTH);
	localparam int CW1 = CW + 1;
	localparam int PROD_W = 2 * NW;
	localparam int INC_W = clem_pkg::COUNT_W + 1;
	localparam int CMP_W = (PROD_W > INC_W) ? PROD_W : INC_W;

	// Pair count index: the larger id selects the row.
	function automatic logic [AW-1:0] pc_addr(input logic [CW-1:0] p, input logic [CW-1:0] q);
		logic [CW-1:0] h;
		logic [CW-1:0] l;
		h = (p > q) ? p : q;
		l = (p > q) ? q : p;
		pc_addr = AW'(h) * AW'(NUM_CL) + AW'(l);
	endfunction

	// Saturating count sum.
	function automatic logic [clem_pkg::COUNT_W-1:0] cnt_sat(input logic [INC_W-1:0] v);
		cnt_sat = v[clem_pkg::COUNT_W] ? clem_pkg::COUNT_MAX : v[clem_pkg::COUNT_W-1:0];
	endfunction

	// Configuration and run state.
	logic [clem_pkg::DIST_W-1:0] thr_q;
	logic [NW-1:0]               npts_q;
	logic                        stopped_q;
	logic [CW-1:0]               next_id_q;
	logic [NUM_CL-1:0]           live_q;
	logic [MAX_POINTS-1:0]       leaf_vld_q;
	logic [NUM_CL-1:0]           size_vld_q;
	logic [AW-1:0]               clr_q;
	logic [CW-1:0]               sweep_q;

	// Item and lookup registers.
	logic [PW-1:0]               a_q;
	logic [PW-1:0]               leaf_ib_q;
	logic [clem_pkg::DIST_W-1:0] dist_q;
	logic [CW-1:0]               hi_q;
	logic [CW-1:0]               lo_q;

	// Memories and their read registers.
	logic [CW-1:0]                leaf_mem [MAX_POINTS];
	logic [NW-1:0]                size_mem [NUM_CL];
	logic [clem_pkg::COUNT_W-1:0] cnt_mem  [CNT_DEPTH];
	logic [CW-1:0]                leaf_rda_q;
	logic [CW-1:0]                leaf_rdb_q;
	logic                         leaf_va_q;
	logic                         leaf_vb_q;
	logic [NW-1:0]                size_hi_rd_q;
	logic [NW-1:0]                size_lo_rd_q;
	logic                         size_hv_q;
	logic                         size_lv_q;
	logic [clem_pkg::COUNT_W-1:0] cnt_rda_q;
	logic [clem_pkg::COUNT_W-1:0] cnt_rdb_q;

	// Sweep pipeline stage.
	logic                         sw_v_s1;
	logic                         lf_v_s1;
	logic [CW-1:0]                sw_x_s1;

	// Output register.
	logic                         out_valid_q;
	logic                         out_merged_q;
	logic                         out_finished_q;
	logic [CW-1:0]                out_larger_q;
	logic [CW-1:0]                out_smaller_q;
	logic [CW-1:0]                out_new_q;
	logic [clem_pkg::DIST_W-1:0]  out_distance_q;

	logic                cfg_wr;
	logic                restart;
	logic [NW-1:0]       npts_wr;
	logic [NW-1:0]       npts_raw;
	logic [CW-1:0]       owner_a;
	logic [CW-1:0]       owner_b;
	logic [CW-1:0]       hi_c;
	logic [CW-1:0]       lo_c;
	logic [NW-1:0]       size_hi;
	logic [NW-1:0]       size_lo;
	logic [PROD_W-1:0]   prod;
	logic [INC_W-1:0]    cnt_inc;
	logic [AW-1:0]       cnt_ra;
	logic [AW-1:0]       cnt_rb;
	logic                cnt_we;
	logic [AW-1:0]       cnt_wa;
	logic [clem_pkg::COUNT_W-1:0] cnt_wd;
	logic [PW-1:0]       leaf_rb_addr;
	logic                leaf_hit;
	logic                sweep_take;

	// Configuration decode; the point count is clamped into range.
	assign cfg_wr   = psel & penable & pwrite;
	assign restart  = cfg_wr & (paddr[2] == clem_pkg::REG_NUM_POINTS);
	assign npts_raw = pwdata[NW-1:0];
	always_comb begin
		if (npts_raw == '0) begin
			npts_wr = NW'(1);
		end else if (npts_raw > NW'(MAX_POINTS)) begin
			npts_wr = NW'(MAX_POINTS);
		end else begin
			npts_wr = npts_raw;
		end
	end
	assign prdata = (paddr[2] == clem_pkg::REG_THRESHOLD) ? thr_q : clem_pkg::APB_DW'(npts_q);

	// Current owners; an unwritten leaf still owns itself.
	assign owner_a = leaf_va_q ? leaf_rda_q : CW'(a_q);
	assign owner_b = leaf_vb_q ? leaf_rdb_q : CW'(leaf_ib_q);
	assign hi_c    = (owner_a > owner_b) ? owner_a : owner_b;
	assign lo_c    = (owner_a > owner_b) ? owner_b : owner_a;

	// Cluster sizes; an unwritten entry is a leaf of size one or empty.
	assign size_hi = size_hv_q ? size_hi_rd_q : ((CW1'(hi_q) < CW1'(MAX_POINTS)) ? NW'(1) : '0);
	assign size_lo = size_lv_q ? size_lo_rd_q : ((CW1'(lo_q) < CW1'(MAX_POINTS)) ? NW'(1) : '0);

	// Count compare against the full pair product.
	assign prod    = PROD_W'(size_hi) * PROD_W'(size_lo);
	assign cnt_inc = INC_W'(cnt_rda_q) + INC_W'(1);

	// Status to the controller.
	assign status.restart    = restart;
	assign status.ignore     = stopped_q | (NW'(point_a) >= npts_q) | (NW'(point_b) >= npts_q);
	assign status.stop_hit   = (dist_q >= thr_q) | (owner_a == owner_b);
	assign status.pair_full  = (CMP_W'(cnt_inc) == CMP_W'(prod));
	assign status.sweep_last = (sweep_q == CW'(NUM_CL - 1));
	assign status.clear_last = (clr_q == AW'(CNT_DEPTH - 1));
	assign status.out_busy   = out_valid_q & ~out_ready;

	// Count memory port selection.
	assign cnt_ra = cmd.eval_own ? pc_addr(hi_c, lo_c) : pc_addr(hi_q, sweep_q);
	assign cnt_rb = pc_addr(lo_q, sweep_q);
	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = pc_addr(next_id_q, sw_x_s1);
		cnt_wd = cnt_sat(INC_W'(cnt_rda_q) + INC_W'(cnt_rdb_q));
		if (cmd.clear_wr) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
			cnt_wd = '0;
		end else if (cmd.upd_cnt) begin
			cnt_we = 1'b1;
			cnt_wa = pc_addr(hi_q, lo_q);
			cnt_wd = cnt_sat(cnt_inc);
		end else if (sw_v_s1) begin
			cnt_we = 1'b1;
		end
	end

	// Sweep helpers.
	assign leaf_rb_addr = cmd.sweep_rd ? sweep_q[PW-1:0] : point_b;
	assign leaf_hit     = lf_v_s1 & ((owner_b == hi_q) | (owner_b == lo_q));
	assign sweep_take   = live_q[sweep_q] & (sweep_q != hi_q) & (sweep_q != lo_q)
		& (sweep_q != next_id_q);

	// Pair count memory.
	always_ff @(posedge clk) begin
		cnt_rda_q <= cnt_mem[cnt_ra];
		cnt_rdb_q <= cnt_mem[cnt_rb];
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
	end

	// Leaf owner memory: two read ports, one relabel write port.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			leaf_rda_q <= leaf_mem[point_a];
			leaf_va_q  <= leaf_vld_q[point_a];
			a_q        <= point_a;
			dist_q     <= distance;
		end
		if (cmd.load_in | cmd.sweep_rd) begin
			leaf_rdb_q <= leaf_mem[leaf_rb_addr];
			leaf_vb_q  <= leaf_vld_q[leaf_rb_addr];
			leaf_ib_q  <= leaf_rb_addr;
		end
		if (leaf_hit) begin
			leaf_mem[sw_x_s1[PW-1:0]] <= next_id_q;
		end
	end

	// Cluster size memory and the merged pair.
	always_ff @(posedge clk) begin
		if (cmd.eval_own) begin
			size_hi_rd_q <= size_mem[hi_c];
			size_lo_rd_q <= size_mem[lo_c];
			size_hv_q    <= size_vld_q[hi_c];
			size_lv_q    <= size_vld_q[lo_c];
			hi_q         <= hi_c;
			lo_q         <= lo_c;
		end
		if (cmd.commit) begin
			size_mem[next_id_q] <= size_hi + size_lo;
		end
	end

	// Sweep index and pipeline stage payload.
	always_ff @(posedge clk) begin
		if (cmd.sweep_rd) begin
			sw_x_s1 <= sweep_q;
		end
	end

	// Control state, valid bits and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= '1;
			npts_q     <= NW'(MAX_POINTS);
			stopped_q  <= 1'b0;
			next_id_q  <= CW'(MAX_POINTS);
			for (int i = 0; i < NUM_CL; i++) begin
				live_q[i] <= (i < MAX_POINTS);
			end
			leaf_vld_q <= '0;
			size_vld_q <= '0;
			clr_q      <= '0;
			sweep_q    <= '0;
			sw_v_s1    <= 1'b0;
			lf_v_s1    <= 1'b0;
		end else begin
			sw_v_s1 <= cmd.sweep_rd & sweep_take;
			lf_v_s1 <= cmd.sweep_rd & (CW1'(sweep_q) < CW1'(MAX_POINTS));
			if (cfg_wr && paddr[2] == clem_pkg::REG_THRESHOLD) begin
				thr_q <= pwdata;
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.upd_cnt) begin
				sweep_q <= '0;
			end else if (cmd.sweep_rd) begin
				sweep_q <= sweep_q + CW'(1);
			end
			if (leaf_hit) begin
				leaf_vld_q[sw_x_s1[PW-1:0]] <= 1'b1;
			end
			if (cmd.commit) begin
				size_vld_q[next_id_q] <= 1'b1;
				live_q[next_id_q]     <= 1'b1;
				live_q[hi_q]          <= 1'b0;
				live_q[lo_q]          <= 1'b0;
				next_id_q             <= next_id_q + CW'(1);
			end
			if (cmd.emit_fin) begin
				stopped_q <= 1'b1;
			end
			if (restart) begin
				npts_q     <= npts_wr;
				stopped_q  <= 1'b0;
				next_id_q  <= CW'(npts_wr);
				for (int i = 0; i < NUM_CL; i++) begin
					live_q[i] <= (CW1'(i) < CW1'(npts_wr));
				end
				leaf_vld_q <= '0;
				size_vld_q <= '0;
				clr_q      <= '0;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_fin | cmd.emit_merge) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; a finished word carries zeros.
	always_ff @(posedge clk) begin
		if (cmd.emit_fin) begin
			out_merged_q   <= 1'b0;
			out_finished_q <= 1'b1;
			out_larger_q   <= '0;
			out_smaller_q  <= '0;
			out_new_q      <= '0;
			out_distance_q <= '0;
		end else if (cmd.emit_merge) begin
			out_merged_q   <= 1'b1;
			out_finished_q <= 1'b0;
			out_larger_q   <= hi_q;
			out_smaller_q  <= lo_q;
			out_new_q      <= next_id_q - CW'(1);
			out_distance_q <= dist_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_merged   = out_merged_q;
	assign out_finished = out_finished_q;
	assign out_larger   = out_larger_q;
	assign out_smaller  = out_smaller_q;
	assign out_new      = out_new_q;
	assign out_distance = out_distance_q;

endmodule

`default_nettype wire

// ----- rtl/clem_checker.sv -----
// ----------------------------------------------------------------------------
// clem_checker
// Port-level checks of the edge merger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clem_checker #(
	parameter int MAX_POINTS = clem_pkg::MAX_POINTS_DEF,
	localparam int CW = $clog2(2 * MAX_POINTS),
	localparam int OUT_W = (3 * CW + clem_pkg::DIST_W + 7) / 8 * 8
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tready,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [OUT_W-1:0]            m_tdata,
	input wire [1:0]                  m_tuser,
	input wire                        psel,
	input wire                        penable,
	input wire                        pwrite,
	input wire [clem_pkg::APB_AW-1:0] paddr
);

	// A new point count starts the clearing pass, which blocks input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == clem_pkg::REG_NUM_POINTS) |=> !s_tready)
		else $error("input taken right after a point count write");

	// A word is either a merge or a finish, never both or neither.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[clem_pkg::FLAG_MERGED] != m_tuser[clem_pkg::FLAG_FINISHED]))
		else $error("result word with bad flags");

	// A new cluster always takes an id above both children.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[clem_pkg::FLAG_MERGED]) |->
		(m_tdata[3*CW-1:2*CW] > m_tdata[CW-1:0]) && (m_tdata[CW-1:0] > m_tdata[2*CW-1:CW]))
		else $error("merge ids out of order");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind complete_linkage_edge_merger_core clem_checker #(
	.MAX_POINTS (MAX_POINTS)
) u_clem_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr)
);

`default_nettype wire
